// ===== rtl/pair_sum_finder_defines.svh =====
// assertion macros for the pair sum finder
// used by the controller and the top level
`ifndef PAIR_SUM_FINDER_DEFINES_SVH
`define PAIR_SUM_FINDER_DEFINES_SVH
`ifndef SYNTHESIS
`define PSF_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("lbl failed");
`define PSF_ASSERT_RST(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) else $error("lbl failed");
`else
`define PSF_ASSERT(lbl, clk, rst_n, prop)
`define PSF_ASSERT_RST(lbl, clk, prop)
`endif
`endif

// ===== rtl/psf_pkg.sv =====
// types and constants of the pair sum finder
// no dependencies
`default_nettype none
package psf_pkg;
	localparam logic [63:0] HASH_MULT = 64'h9E3779B97F4A7C15;
	localparam int VALUE_W = 64;
	localparam int OUT_POS_W = 20;
	localparam int TABLE_SLOTS = 1024;
	localparam int IDX_W = $clog2(TABLE_SLOTS);
	localparam int EPOCH_W = 8;

	typedef enum logic [2:0] {
		ST_STORED = 3'd0,
		ST_MATCH = 3'd1,
		ST_FULL = 3'd2,
		ST_END = 3'd3,
		ST_IGNORED = 3'd4
	} status_t;

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_HASH_C, S_HOME_C, S_READ_C, S_CHECK_C,
		S_HASH_V, S_HOME_V, S_READ_V, S_CHECK_V, S_WRITE, S_OUT
	} state_t;

	typedef struct packed {
		logic load;       // capture request
		logic hash_comp;  // start multiplier on complement
		logic hash_val;   // start multiplier on value
		logic set_home;   // probe index from hash
		logic rd;         // slot read state; unused by the datapath
		logic step;       // advance probe index
		logic wr;         // write slot
		logic clr_wr;     // clear pass write
		logic clr_step;
		logic set_partner;
		logic advance;    // position counter step / last reset
	} cmd_t;

	typedef struct packed {
		logic hit_comp;   // valid and key equals complement
		logic hit_val;    // valid and key equals value
		logic slot_valid;
		logic probe_done; // probe limit reached
		logic last;
		logic pair_found;
		logic clr_done;
		logic epoch_wrap; // last epoch in use
	} sts_t;
endpackage
`default_nettype wire

// ===== rtl/psf_if.sv =====
// valid/ready channel interface
// depends on nothing
`default_nettype none
interface psf_if #(parameter int W = 1);
	logic valid;
	logic ready;
	logic [W-1:0] data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/pair_sum_finder.sv =====
// pair sum finder: an ignored request goes from the hash state straight to the result;
// otherwise up to PROBE_LIMIT slots are probed for the complement, and on no match up to
// PROBE_LIMIT slots for the value, which is stored in the first free or equal slot found
// one request in flight at a time; a waiting result holds off the next request
// arst_n clears target, position and match flag; a pass clearing every slot tag follows
// reset and every 255th sequence end before requests are taken
`default_nettype none
`include "pair_sum_finder_defines.svh"
module pair_sum_finder #(
	parameter int PROBE_LIMIT = 8,
	parameter int POSITION_BITS = 20
) (
	input wire logic clk,
	input wire logic arst_n,
	psf_if.sink req,
	psf_if.source rsp,
	psf_if.sink cfg
);
	psf_pkg::cmd_t cmd;
	psf_pkg::sts_t sts;
	psf_pkg::status_t status;
	logic [POSITION_BITS-1:0] cur_pos, partner_pos;
	logic [psf_pkg::OUT_POS_W-1:0] cur_o, partner_o, cur_q;

	// request data: {last, value}; response data: {status, current, partner}
	assign cfg.ready = 1'b1;

	psf_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(req.valid), .in_ready(req.ready),
		.out_valid(rsp.valid), .out_ready(rsp.ready),
		.status(status), .cmd(cmd), .sts(sts));

	psf_datapath #(.PROBE_LIMIT(PROBE_LIMIT),
		.POSITION_BITS(POSITION_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.value(req.data[63:0]), .last(req.data[64]),
		.cfg_we(cfg.valid), .cfg_data(cfg.data[63:0]),
		.cur_pos(cur_pos), .partner_pos(partner_pos));

	always_comb begin
		cur_o = '0;
		partner_o = '0;
		cur_o[psf_pkg::OUT_POS_W-1:0] = psf_pkg::OUT_POS_W'(cur_pos);
		partner_o = psf_pkg::OUT_POS_W'(partner_pos);
	end

	// position is captured before the counter advances
	always_ff @(posedge clk) begin
		if (cmd.advance) begin
			cur_q <= cur_o;
		end
	end

	assign rsp.data = {status, cur_q,
		(status == psf_pkg::ST_MATCH) ? partner_o : psf_pkg::OUT_POS_W'(0)};

	`PSF_ASSERT(a_no_accept_busy, clk, arst_n, (req.valid && req.ready) |=> !req.ready)
	`PSF_ASSERT_RST(a_rst_idle, clk, !arst_n |-> !rsp.valid)
endmodule
`default_nettype wire

// ===== rtl/psf_ram.sv =====
// generic single port ram with registered read
// no dependencies
`default_nettype none
module psf_ram #(parameter int WIDTH = 8, parameter int DEPTH = 16) (
	input wire logic clk,
	input wire logic we,
	input wire logic [$clog2(DEPTH)-1:0] addr,
	input wire logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule
`default_nettype wire

// ===== rtl/psf_datapath.sv =====
// datapath: hash, probe index, slot memories, result
// depends on psf_pkg and psf_ram
`default_nettype none
module psf_datapath #(
	parameter int PROBE_LIMIT = 8,
	parameter int POSITION_BITS = 20
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire psf_pkg::cmd_t cmd,
	output psf_pkg::sts_t sts,
	input wire logic [63:0] value,
	input wire logic last,
	input wire logic cfg_we,
	input wire logic [63:0] cfg_data,
	output logic [POSITION_BITS-1:0] cur_pos,
	output logic [POSITION_BITS-1:0] partner_pos
);
	localparam int IW = psf_pkg::IDX_W;
	localparam int PW = $clog2(PROBE_LIMIT + 1);
	localparam int EW = psf_pkg::EPOCH_W;
	localparam logic [63:0] MULT = psf_pkg::HASH_MULT;

	logic [63:0] target_q, value_q, comp_q;
	logic last_q, found_q;
	logic [IW-1:0] idx_q, addr, hlo_q, hx1_q, hx2_q;
	logic [PW-1:0] probe_q;
	logic [POSITION_BITS-1:0] pos_q, partner_q;
	logic [63:0] key_rd, hkey, hprod;
	logic [POSITION_BITS-1:0] pos_rd;
	logic [EW-1:0] epoch_q, tag_rd, tag_wd;
	logic [IW-1:0] clr_q;
	logic we, tag_we;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= '0;
			epoch_q <= EW'(1);
			pos_q <= '0;
			found_q <= 1'b0;
			clr_q <= '0;
		end else begin
			if (cfg_we) begin
				target_q <= cfg_data;
			end
			if (cmd.set_partner) begin
				found_q <= 1'b1;
			end
			if (cmd.advance) begin
				if (last_q) begin
					epoch_q <= (epoch_q == '1) ? EW'(1) : epoch_q + 1'b1;
					pos_q <= '0;
					found_q <= 1'b0;
				end else begin
					pos_q <= pos_q + 1'b1;
				end
			end
			if (cmd.clr_step) begin
				clr_q <= clr_q + 1'b1;
			end
		end
	end

	// bits 41:32 of the 64 bit product from a 32x32 product and two narrow cross terms
	assign hkey = cmd.hash_val ? value_q : comp_q;
	assign hprod = {32'd0, hkey[31:0]} * {32'd0, MULT[31:0]};

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			value_q <= value;
			last_q <= last;
			comp_q <= target_q - value;
			partner_q <= '0;
		end
		if (cmd.hash_comp || cmd.hash_val) begin
			hlo_q <= hprod[32 +: IW];
			hx1_q <= hkey[32 +: IW] * MULT[IW-1:0];
			hx2_q <= hkey[IW-1:0] * MULT[32 +: IW];
		end
		if (cmd.set_home) begin
			idx_q <= hlo_q + hx1_q + hx2_q;
			probe_q <= '0;
		end
		if (cmd.step) begin
			idx_q <= idx_q + 1'b1;
			probe_q <= probe_q + 1'b1;
		end
		if (cmd.set_partner) begin
			partner_q <= pos_rd;
		end
	end

	// slot tags hold the epoch of their write, cleared by a pass
	assign we = cmd.wr;
	assign tag_we = cmd.wr || cmd.clr_wr;
	assign tag_wd = cmd.clr_wr ? '0 : epoch_q;
	assign addr = cmd.clr_wr ? clr_q : idx_q;
	psf_ram #(.WIDTH(64), .DEPTH(psf_pkg::TABLE_SLOTS)) u_key (
		.clk(clk), .we(we), .addr(addr), .wdata(value_q), .rdata(key_rd));
	psf_ram #(.WIDTH(POSITION_BITS), .DEPTH(psf_pkg::TABLE_SLOTS)) u_pos (
		.clk(clk), .we(we), .addr(addr), .wdata(pos_q), .rdata(pos_rd));
	psf_ram #(.WIDTH(EW), .DEPTH(psf_pkg::TABLE_SLOTS)) u_tag (
		.clk(clk), .we(tag_we), .addr(addr), .wdata(tag_wd), .rdata(tag_rd));

	always_comb begin
		sts.slot_valid = (tag_rd == epoch_q);
		sts.hit_comp = sts.slot_valid && (key_rd == comp_q);
		sts.hit_val = sts.slot_valid && (key_rd == value_q);
		sts.probe_done = (probe_q == PW'(PROBE_LIMIT - 1));
		sts.last = last_q;
		sts.pair_found = found_q;
		sts.clr_done = (clr_q == IW'(psf_pkg::TABLE_SLOTS - 1));
		sts.epoch_wrap = (epoch_q == '1);
	end

	assign cur_pos = pos_q;
	assign partner_pos = partner_q;
	logic unused;
	assign unused = cmd.rd;
endmodule
`default_nettype wire

// ===== rtl/psf_ctrl.sv =====
// controller state machine of the pair sum finder
// depends on psf_pkg and pair_sum_finder_defines.svh
`default_nettype none
`include "pair_sum_finder_defines.svh"
module psf_ctrl (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input wire logic out_ready,
	output psf_pkg::status_t status,
	output psf_pkg::cmd_t cmd,
	input wire psf_pkg::sts_t sts
);
	psf_pkg::state_t state_q, state_d;
	psf_pkg::status_t status_q, status_d;
	logic ovalid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= psf_pkg::S_CLEAR;
			ovalid_q <= 1'b0;
			status_q <= psf_pkg::ST_STORED;
		end else begin
			state_q <= state_d;
			status_q <= status_d;
			if (out_ready) begin
				ovalid_q <= 1'b0;
			end
			if (state_q == psf_pkg::S_OUT) begin
				ovalid_q <= 1'b1;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		status_d = status_q;
		case (state_q)
			psf_pkg::S_CLEAR: begin
				if (sts.clr_done) begin
					state_d = psf_pkg::S_IDLE;
				end
			end
			psf_pkg::S_IDLE: begin
				if (in_valid) begin
					state_d = psf_pkg::S_HASH_C;
				end
			end
			psf_pkg::S_HASH_C: begin
				if (sts.pair_found) begin
					status_d = psf_pkg::ST_IGNORED;
					state_d = psf_pkg::S_OUT;
				end else begin
					state_d = psf_pkg::S_HOME_C;
				end
			end
			psf_pkg::S_HOME_C: state_d = psf_pkg::S_READ_C;
			psf_pkg::S_READ_C: state_d = psf_pkg::S_CHECK_C;
			psf_pkg::S_CHECK_C: begin
				if (sts.hit_comp) begin
					status_d = psf_pkg::ST_MATCH;
					state_d = psf_pkg::S_OUT;
				end else if (!sts.slot_valid || sts.probe_done) begin
					state_d = psf_pkg::S_HASH_V;
				end else begin
					state_d = psf_pkg::S_READ_C;
				end
			end
			psf_pkg::S_HASH_V: state_d = psf_pkg::S_HOME_V;
			psf_pkg::S_HOME_V: state_d = psf_pkg::S_READ_V;
			psf_pkg::S_READ_V: state_d = psf_pkg::S_CHECK_V;
			psf_pkg::S_CHECK_V: begin
				if (!sts.slot_valid || sts.hit_val) begin
					state_d = psf_pkg::S_WRITE;
				end else if (sts.probe_done) begin
					status_d = sts.last ? psf_pkg::ST_END : psf_pkg::ST_FULL;
					state_d = psf_pkg::S_OUT;
				end else begin
					state_d = psf_pkg::S_READ_V;
				end
			end
			psf_pkg::S_WRITE: begin
				status_d = sts.last ? psf_pkg::ST_END : psf_pkg::ST_STORED;
				state_d = psf_pkg::S_OUT;
			end
			psf_pkg::S_OUT: begin
				state_d = (sts.last && sts.epoch_wrap) ? psf_pkg::S_CLEAR : psf_pkg::S_IDLE;
			end
			default: state_d = psf_pkg::S_IDLE;
		endcase
		// hold new request until the previous result has been taken
		if (state_q == psf_pkg::S_IDLE && ovalid_q && !out_ready) begin
			state_d = psf_pkg::S_IDLE;
		end
	end

	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		case (state_q)
			psf_pkg::S_CLEAR: begin
				cmd.clr_wr = 1'b1;
				cmd.clr_step = 1'b1;
			end
			psf_pkg::S_IDLE: begin
				in_ready = !ovalid_q || out_ready;
				cmd.load = in_valid && in_ready;
			end
			psf_pkg::S_HASH_C: cmd.hash_comp = 1'b1;
			psf_pkg::S_HOME_C: cmd.set_home = 1'b1;
			psf_pkg::S_READ_C: cmd.rd = 1'b1;
			psf_pkg::S_CHECK_C: begin
				cmd.set_partner = sts.hit_comp;
				cmd.step = !sts.hit_comp && sts.slot_valid && !sts.probe_done;
			end
			psf_pkg::S_HASH_V: cmd.hash_val = 1'b1;
			psf_pkg::S_HOME_V: cmd.set_home = 1'b1;
			psf_pkg::S_READ_V: cmd.rd = 1'b1;
			psf_pkg::S_CHECK_V: begin
				cmd.step = sts.slot_valid && !sts.hit_val && !sts.probe_done;
			end
			psf_pkg::S_WRITE: cmd.wr = 1'b1;
			psf_pkg::S_OUT: cmd.advance = 1'b1;
			default: cmd = '0;
		endcase
	end

	assign out_valid = ovalid_q;
	assign status = status_q;

	`PSF_ASSERT(a_ready_idle, clk, arst_n, in_ready |-> (state_q == psf_pkg::S_IDLE))
	`PSF_ASSERT(a_out_after, clk, arst_n, (state_q == psf_pkg::S_OUT) |=> out_valid)
	`PSF_ASSERT(a_wr_once, clk, arst_n, cmd.wr |=> (state_q == psf_pkg::S_OUT))
endmodule
`default_nettype wire

// ===== test/tb_pair_sum_finder.sv =====
// testbench for pair_sum_finder: sequences of signed values, checked against
// an in-bench hash table predictor; depends on psf_pkg and psf_if
`timescale 1ns / 100ps
module tb_pair_sum_finder;
	localparam int SLOTS = 1024;
	localparam int PROBES = 8;
	localparam int GUARD_CYCLES = 60;
	localparam int CYCLE_LIMIT = 900000;

	typedef struct {
		logic [63:0] value;
		logic last;
	} seq_item_t;

	typedef struct {
		psf_pkg::status_t status;
		logic [19:0] cur_pos;
		logic [19:0] partner_pos;
	} pair_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b1;
	always #5 clk = ~clk;

	psf_if #(.W(65)) req_if();
	psf_if #(.W(43)) rsp_if();
	psf_if #(.W(64)) cfg_if();

	pair_sum_finder u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_if),
		.rsp(rsp_if),
		.cfg(cfg_if)
	);

	// predictor state
	logic [63:0] target_sum = '0;
	logic [63:0] slot_key [SLOTS];
	logic [19:0] slot_pos [SLOTS];
	logic slot_used [SLOTS];
	logic [19:0] seq_pos = '0;
	logic matched = 1'b0;

	seq_item_t pending_q [$];
	pair_result_t expected_q [$];
	seq_item_t in_flight;
	int errors = 0;
	int cycles = 0;
	int send_gap = 0;
	int recv_stall = 0;
	bit no_idle = 0;
	logic [63:0] clash_keys [$];

	function automatic logic [9:0] home_slot(logic [63:0] k);
		logic [63:0] h;
		h = k * psf_pkg::HASH_MULT;
		return h[41:32];
	endfunction

	task automatic predict_pair(seq_item_t it);
		pair_result_t r;
		logic [63:0] comp;
		logic [9:0] idx;
		logic hit;
		logic stored;
		r.cur_pos = seq_pos;
		r.partner_pos = '0;
		hit = 1'b0;
		stored = 1'b0;
		if (matched) begin
			r.status = psf_pkg::ST_IGNORED;
		end else begin
			comp = target_sum - it.value;
			idx = home_slot(comp);
			for (int n = 0; n < PROBES; n++) begin
				if (!slot_used[idx]) break;
				if (slot_key[idx] == comp) begin
					hit = 1'b1;
					r.partner_pos = slot_pos[idx];
					break;
				end
				idx++;
			end
			if (hit) begin
				matched = 1'b1;
				r.status = psf_pkg::ST_MATCH;
			end else begin
				idx = home_slot(it.value);
				for (int n = 0; n < PROBES; n++) begin
					if (!slot_used[idx] || slot_key[idx] == it.value) begin
						slot_used[idx] = 1'b1;
						slot_key[idx] = it.value;
						slot_pos[idx] = seq_pos;
						stored = 1'b1;
						break;
					end
					idx++;
				end
				r.status = it.last ? psf_pkg::ST_END
					: (stored ? psf_pkg::ST_STORED : psf_pkg::ST_FULL);
			end
		end
		expected_q.insert(expected_q.size(), r);
		seq_pos = seq_pos + 20'd1;
		if (it.last) begin
			foreach (slot_used[i]) slot_used[i] = 1'b0;
			seq_pos = '0;
			matched = 1'b0;
		end
	endtask

	task automatic report(string what, logic [63:0] got, logic [63:0] want);
		errors++;
		$display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, want, cycles);
	endtask

	// request driver
	always @(posedge clk) begin
		if (!arst_n) begin
			req_if.valid <= 1'b0;
			req_if.data <= '0;
		end else begin
			if (req_if.valid && req_if.ready) predict_pair(in_flight);
			if (!(req_if.valid && !req_if.ready)) begin
				if (send_gap > 0) begin
					send_gap--;
					req_if.valid <= 1'b0;
				end else if (pending_q.size() > 0) begin
					in_flight = pending_q.pop_front();
					req_if.valid <= 1'b1;
					req_if.data <= {in_flight.last, in_flight.value};
					send_gap = no_idle ? 0 : $urandom_range(0, 14);
				end else begin
					req_if.valid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		pair_result_t e;
		if (!arst_n) begin
			rsp_if.ready <= 1'b0;
		end else begin
			if (rsp_if.valid && rsp_if.ready) begin
				if (expected_q.size() == 0) begin
					report("unexpected result", rsp_if.data, '0);
				end else begin
					e = expected_q.pop_front();
					if (rsp_if.data[42:40] != e.status)
						report("status", rsp_if.data[42:40], e.status);
					if (rsp_if.data[39:20] != e.cur_pos)
						report("current_position", rsp_if.data[39:20], e.cur_pos);
					if (rsp_if.data[19:0] != e.partner_pos)
						report("partner_position", rsp_if.data[19:0], e.partner_pos);
				end
				recv_stall = no_idle ? 0 : $urandom_range(0, 14);
			end
			if (recv_stall > 0) begin
				recv_stall--;
				rsp_if.ready <= 1'b0;
			end else begin
				rsp_if.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_pair_sum_finder: FAIL");
			$finish;
		end
	end

	task automatic push_item(logic [63:0] v, logic l);
		seq_item_t it;
		it.value = v;
		it.last = l;
		pending_q.insert(pending_q.size(), it);
	endtask

	task automatic drain();
		while (pending_q.size() > 0 || req_if.valid || expected_q.size() > 0)
			@(posedge clk);
		repeat (GUARD_CYCLES) @(posedge clk);
	endtask

	task automatic write_target(logic [63:0] t);
		cfg_if.valid <= 1'b1;
		cfg_if.data <= t;
		do @(posedge clk); while (!cfg_if.ready);
		cfg_if.valid <= 1'b0;
		target_sum = t;
	endtask

	// random sequences with planted pairs, colliding keys and noise
	task automatic random_phase(int n_items);
		logic [63:0] seen [$];
		logic [63:0] v;
		int len;
		int k;
		k = 0;
		while (k < n_items) begin
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 20);
			seen.delete();
			for (int i = 0; i < len; i++) begin
				case ($urandom_range(0, 9))
					0, 1: v = {$urandom, $urandom};
					2: v = clash_keys[$urandom_range(0, clash_keys.size() - 1)];
					3: v = ($urandom_range(0, 1)) ? 64'h7FFF_FFFF_FFFF_FFFF
						: 64'h8000_0000_0000_0000;
					4, 5: v = (seen.size() > 0 && $urandom_range(0, 2) != 0)
						? target_sum - seen[$urandom_range(0, seen.size() - 1)]
						: {$urandom, $urandom};
					default: v = 64'($signed($urandom_range(0, 400)) - 200);
				endcase
				seen.insert(seen.size(), v);
				push_item(v, (i == len - 1) ? 1'b1 : ($urandom_range(0, 49) == 0));
				k++;
			end
		end
	endtask

	initial begin
		logic [63:0] c;
		logic [63:0] targets [5];
		arst_n <= 1'b0;
		foreach (slot_used[i]) slot_used[i] = 1'b0;
		cfg_if.valid = 1'b0;
		cfg_if.data = '0;
		req_if.valid = 1'b0;
		req_if.data = '0;
		rsp_if.ready = 1'b0;
		c = 64'd1;
		while (clash_keys.size() < 12) begin
			if (home_slot(c) == 10'd77) clash_keys.insert(clash_keys.size(), c);
			c++;
		end
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: target at reset value 0
		push_item(64'h7FFF_FFFF_FFFF_FFFF, 1'b0);
		push_item(64'h8000_0000_0000_0000, 1'b0);
		push_item(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
		push_item(64'd0, 1'b0);
		push_item(64'd0, 1'b0);
		push_item(64'd5, 1'b0);
		push_item(64'd1, 1'b1);
		push_item(64'd9, 1'b1);
		for (int i = 0; i < 11; i++) push_item(clash_keys[i], i == 10);
		drain();
		write_target(64'd10);
		push_item(64'd3, 1'b0);
		push_item(64'd3, 1'b0);
		push_item(64'd7, 1'b0);
		push_item(64'd2, 1'b1);
		push_item(64'd4, 1'b1);
		drain();

		targets[0] = 64'h7FFF_FFFF_FFFF_FFFF;
		targets[1] = 64'h8000_0000_0000_0000;
		targets[2] = 64'hFFFF_FFFF_FFFF_FFFF;
		targets[3] = 64'd0;
		targets[4] = {$urandom, $urandom};
		for (int p = 0; p < 5; p++) begin
			write_target(targets[p]);
			no_idle = (p == 2);
			random_phase(226);
			drain();
		end

		if (errors == 0) begin
			$display("tb_pair_sum_finder: PASS");
		end else begin
			$display("tb_pair_sum_finder: FAIL");
		end
		$finish;
	end
endmodule
